// ===== rtl/bfsh_pkg.sv =====
// ----------------------------------------------------------------------------
// bfsh_pkg: shared types, constants and helpers
// Table size, index constants, modular reduction and the controller/datapath
// command and status bundles for the sum-hash bloom filter.
// ----------------------------------------------------------------------------
package bfsh_pkg;

    // number of one-bit marks in the filter
    localparam int TABLE_BITS = 100;

    // width of a residue modulo TABLE_BITS
    localparam int SUM_W = $clog2(TABLE_BITS);

    // width of the values that get reduced: sum + byte, or 4s + 7 at most
    localparam int RED_W = $clog2(4 * TABLE_BITS + 256);

    // largest quotient seen by the reduction, and the subtract steps it needs
    localparam int RED_QMAX  = (4 * TABLE_BITS + 255) / TABLE_BITS;
    localparam int RED_STEPS = $clog2(RED_QMAX + 1);

    // hash constants: index = (mul * s + add) mod TABLE_BITS
    localparam int IDX_ADD_A = 5;   // 3s + 5
    localparam int IDX_ADD_B = 7;   // 4s + 7
    localparam int IDX_ADD_C = 9;   // 2s + 9

    // which of the three indexes is being formed
    typedef enum logic [1:0] {
        SEL_A,
        SEL_B,
        SEL_C
    } idx_sel_t;

    // controller states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_IDX1,
        ST_IDX2,
        ST_IDX3,
        ST_DONE
    } state_t;

    // commands from the controller to the datapath
    typedef struct packed {
        logic     take_byte;    // a key byte beat is accepted this cycle
        logic     calc_idx;     // form an index into the index register
        idx_sel_t idx_sel;      // which index to form
        logic     mark_access;  // set or test the mark at the index register
        logic     push_result;  // load the lookup answer into the output stage
    } cmd_t;

    // status from the datapath to the controller
    typedef struct packed {
        logic is_lookup;        // the key just closed is a lookup
        logic out_free;         // output stage can take a result this cycle
    } status_t;

    // modulo TABLE_BITS by restoring subtraction of shifted multiples
    function automatic logic [SUM_W-1:0] mod_table(input logic [RED_W-1:0] x);
        logic [RED_W-1:0] r;
        logic [RED_W-1:0] m;
        r = x;
        for (int k = RED_STEPS - 1; k >= 0; k--) begin
            m = RED_W'(TABLE_BITS) << k;
            if (r >= m) begin
                r = r - m;
            end
        end
        return r[SUM_W-1:0];
    endfunction

endpackage

// ===== rtl/bfsh_ctrl.sv =====
// ----------------------------------------------------------------------------
// bfsh_ctrl: sequencer for the sum-hash bloom filter
// Accepts key byte beats, then steps through the three mark indexes of a
// closed key, one mark access per cycle, and hands lookup answers on.
// ----------------------------------------------------------------------------
module bfsh_ctrl
    import bfsh_pkg::*;
(
    input  logic    aclk,
    input  logic    aresetn,
    input  logic    s_tvalid,
    input  logic    s_tlast,
    output logic    s_tready,
    input  status_t status,
    output cmd_t    cmd
);

    state_t state_reg;
    state_t state_next;

    // state register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_tvalid && s_tlast) begin
                    state_next = ST_IDX1;
                end
            end
            ST_IDX1: state_next = ST_IDX2;
            ST_IDX2: state_next = ST_IDX3;
            ST_IDX3: state_next = ST_DONE;
            ST_DONE: begin
                if (!status.is_lookup || status.out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // outputs
    always_comb begin
        s_tready        = 1'b0;
        cmd.take_byte   = 1'b0;
        cmd.calc_idx    = 1'b0;
        cmd.idx_sel     = SEL_A;
        cmd.mark_access = 1'b0;
        cmd.push_result = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                s_tready      = 1'b1;
                cmd.take_byte = s_tvalid;
            end
            ST_IDX1: begin
                cmd.calc_idx = 1'b1;
                cmd.idx_sel  = SEL_A;
            end
            ST_IDX2: begin
                cmd.calc_idx    = 1'b1;
                cmd.idx_sel     = SEL_B;
                cmd.mark_access = 1'b1;
            end
            ST_IDX3: begin
                cmd.calc_idx    = 1'b1;
                cmd.idx_sel     = SEL_C;
                cmd.mark_access = 1'b1;
            end
            ST_DONE: begin
                cmd.mark_access = 1'b1;
                cmd.push_result = status.is_lookup && status.out_free;
            end
            default: begin
                s_tready = 1'b0;
            end
        endcase
    end

endmodule

// ===== rtl/bfsh_dp.sv =====
// ----------------------------------------------------------------------------
// bfsh_dp: datapath of the sum-hash bloom filter
// Running byte sum modulo the table size, index generation, the mark array
// with one access per cycle, and the registered result stage.
// ----------------------------------------------------------------------------
module bfsh_dp
    import bfsh_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  cmd_t       cmd,
    output status_t    status,
    input  logic       s_tuser,
    input  logic [7:0] s_tdata,
    input  logic       s_tlast,
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata
);

    logic [SUM_W-1:0]      sum_reg;
    logic [SUM_W-1:0]      sum_next;
    logic [SUM_W-1:0]      key_sum_reg;
    logic                  lookup_reg;
    logic [SUM_W-1:0]      idx_reg;
    logic [SUM_W-1:0]      idx_next;
    logic                  hit_reg;
    logic [TABLE_BITS-1:0] marks_reg;
    logic                  mark_bit;
    logic                  m_valid_reg;
    logic                  present_reg;
    logic [RED_W-1:0]      s_ext;
    logic [RED_W-1:0]      idx_raw;

    // running sum with this byte folded in
    assign sum_next = mod_table(RED_W'(sum_reg) + RED_W'(s_tdata));

    // running sum, cleared after the last byte, and key sum register, loaded with the full key sum on the last byte
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sum_reg <= '0;
        end else if (cmd.take_byte) begin
            sum_reg <= s_tlast ? '0 : sum_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.take_byte && s_tlast) begin
            key_sum_reg <= sum_next;
            lookup_reg  <= s_tuser;
        end
    end

    // index generation: 3s+5, 4s+7, 2s+9 modulo the table size
    assign s_ext = RED_W'(key_sum_reg);

    always_comb begin
        case (cmd.idx_sel)
            SEL_A:   idx_raw = (s_ext << 1) + s_ext + RED_W'(IDX_ADD_A);
            SEL_B:   idx_raw = (s_ext << 2) + RED_W'(IDX_ADD_B);
            SEL_C:   idx_raw = (s_ext << 1) + RED_W'(IDX_ADD_C);
            default: idx_raw = '0;
        endcase
    end

    assign idx_next = mod_table(idx_raw);

    always_ff @(posedge aclk) begin
        if (cmd.calc_idx) begin
            idx_reg <= idx_next;
        end
    end

    // mark array, one set or test a cycle
    assign mark_bit = marks_reg[idx_reg];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            marks_reg <= '0;
        end else if (cmd.mark_access && !lookup_reg) begin
            marks_reg[idx_reg] <= 1'b1;
        end
    end

    // lookup hit accumulates over the three marks
    always_ff @(posedge aclk) begin
        if (cmd.calc_idx && cmd.idx_sel == SEL_A) begin
            hit_reg <= 1'b1;
        end else if (cmd.mark_access) begin
            hit_reg <= hit_reg & mark_bit;
        end
    end

    // output stage, free again once its beat is taken
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (cmd.push_result) begin
            m_valid_reg <= 1'b1;
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.push_result) begin
            present_reg <= hit_reg & mark_bit;
        end
    end

    assign m_tvalid         = m_valid_reg;
    assign m_tdata          = {7'b0, present_reg};
    assign status.is_lookup = lookup_reg;
    assign status.out_free  = !m_valid_reg || m_tready;

    // running sum always a valid residue
    assert property (@(posedge aclk) disable iff (!aresetn)
        sum_reg < SUM_W'(TABLE_BITS))
        else $error("running sum out of range");

    // every accessed mark lies inside the table
    assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.mark_access |-> idx_reg < SUM_W'(TABLE_BITS))
        else $error("mark index out of range");

    // a result is only loaded when the output stage can take it
    assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.push_result |-> (!m_valid_reg || m_tready))
        else $error("result pushed over a waiting beat");

    // the last byte of a key restarts the sum
    assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.take_byte && s_tlast) |=> sum_reg == '0)
        else $error("running sum not cleared after key");

endmodule

// ===== rtl/bloom_filter_sum_hash.sv =====
// ----------------------------------------------------------------------------
// bloom_filter_sum_hash: bloom filter with a byte-sum hash
// Keys stream in one byte per beat; the last byte inserts the key or looks
// it up and, for a lookup, returns one present beat.
// ----------------------------------------------------------------------------
// Each key byte that is not the last is taken as soon as it is valid, so a
// key streams at one byte per clock. The last byte closes the key and holds
// the input while the three mark indexes are formed and the single mark port
// visits them one per cycle. A lookup answer sits in an output register; the
// block goes on taking bytes while it waits, and only stalls at the end of
// the next lookup if that answer has still not been taken. All marks clear
// at reset; there is no clearing pass.
module bloom_filter_sum_hash
    import bfsh_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,   // [7:0] key_byte
    input  logic       s_tuser,   // [0] command: 0 insert, 1 lookup
    input  logic       s_tlast,
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata    // [0] present, [7:1] zero
);

    cmd_t    cmd;
    status_t status;

    // sequencer
    bfsh_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tlast  (s_tlast),
        .s_tready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    // sum, index and mark datapath
    bfsh_dp u_dp (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cmd      (cmd),
        .status   (status),
        .s_tuser  (s_tuser),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

endmodule
